// ===== sv/dpg_pkg.sv =====
// ---------------------------------------------------------------------------
// dpg_pkg: shared types for the drain pump guard controller
// Op and fault codes, register indexes, and the item, result, configuration
// and controller state records.
// ---------------------------------------------------------------------------
package dpg_pkg;

  localparam int LEVEL_W = 7;
  localparam int TIME_W  = 32;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  localparam logic AUTO_MODE = 1'b0;
  localparam logic HAND_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE   = 2'd0,
    OP_TOGGLE   = 2'd1,
    OP_SET_MODE = 2'd2,
    OP_BUTTON   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_TIMEOUT = 2'd1,
    FAULT_DRAIN   = 2'd2
  } fault_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_START_LEVEL    = 3'd0,
    REG_STOP_LEVEL     = 3'd1,
    REG_DANGER_LEVEL   = 3'd2,
    REG_MAX_RUNTIME    = 3'd3,
    REG_CHECK_INTERVAL = 3'd4,
    REG_MIN_DROP       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] stop_level;
    logic [LEVEL_W-1:0] danger_level;
    logic [TIME_W-1:0]  max_runtime_ms;
    logic [TIME_W-1:0]  check_interval_ms;
    logic [LEVEL_W-1:0] min_drop;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               mode_req;
    logic [LEVEL_W-1:0] sump_level;
    logic [LEVEL_W-1:0] tank_level;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic               pump_on;
    logic               mode;
    logic [1:0]         fault;
    logic [TIME_W-1:0]  runtime_ms;
  } result_t;

  typedef struct packed {
    logic               running;
    logic               cur_mode;
    fault_t             fault;
    logic [TIME_W-1:0]  run_start_ms;
    logic [TIME_W-1:0]  check_start_ms;
    logic [LEVEL_W-1:0] check_start_level;
  } state_t;

endpackage

// ===== sv/dpg_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// dpg_cfg_regs: configuration register file
// Six thresholds and time limits, written one at a time by index.
// ---------------------------------------------------------------------------
module dpg_cfg_regs import dpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_level       <= LEVEL_W'(70);
      cfg.stop_level        <= LEVEL_W'(30);
      cfg.danger_level      <= LEVEL_W'(90);
      cfg.max_runtime_ms    <= TIME_W'(600000);
      cfg.check_interval_ms <= TIME_W'(60000);
      cfg.min_drop          <= LEVEL_W'(5);
    end else if (cfg_valid) begin
      // indexes past the list are dropped
      case (cfg_index)
        REG_START_LEVEL:    cfg.start_level       <= cfg_data[LEVEL_W-1:0];
        REG_STOP_LEVEL:     cfg.stop_level        <= cfg_data[LEVEL_W-1:0];
        REG_DANGER_LEVEL:   cfg.danger_level      <= cfg_data[LEVEL_W-1:0];
        REG_MAX_RUNTIME:    cfg.max_runtime_ms    <= cfg_data[TIME_W-1:0];
        REG_CHECK_INTERVAL: cfg.check_interval_ms <= cfg_data[TIME_W-1:0];
        REG_MIN_DROP:       cfg.min_drop          <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/dpg_core.sv =====
// ---------------------------------------------------------------------------
// dpg_core: input register, controller state and event decision
// One registered event is applied to the pump state per cycle while the
// output register can accept it, and the resulting status is handed to that register.
// ---------------------------------------------------------------------------
module dpg_core import dpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic   item_valid;
  item_t  item;
  state_t state;
  state_t state_next;
  logic   advance;

  assign advance   = item_valid && res_ready;
  assign in_ready  = !item_valid || res_ready;
  assign res_valid = item_valid;

  function automatic state_t drive(state_t s, logic on, logic [LEVEL_W-1:0] sump,
                                   logic [LEVEL_W-1:0] tank, logic [TIME_W-1:0] now,
                                   logic [LEVEL_W-1:0] danger);
    state_t r;
    r = s;
    if (!((on && (s.fault != FAULT_NONE || tank >= danger)) || s.running == on)) begin
      r.running = on;
      if (on) begin
        r.run_start_ms      = now;
        r.check_start_ms    = now;
        r.check_start_level = sump;
      end else begin
        r.run_start_ms   = '0;
        r.check_start_ms = '0;
      end
    end
    return r;
  endfunction

  always_comb begin
    state_t             s;
    logic [TIME_W-1:0]  run_el;
    logic [TIME_W-1:0]  chk_el;
    logic signed [LEVEL_W:0] drop;
    logic               new_mode;
    s        = state;
    run_el   = item.now_ms - state.run_start_ms;
    chk_el   = item.now_ms - state.check_start_ms;
    drop     = $signed({1'b0, state.check_start_level}) - $signed({1'b0, item.sump_level});
    new_mode = (item.op == OP_TOGGLE) ? !state.cur_mode : item.mode_req;
    unique case (op_t'(item.op))
      OP_UPDATE: begin
        priority if (item.tank_level >= cfg.danger_level) begin
          s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms, cfg.danger_level);
        end else if (s.running && run_el >= cfg.max_runtime_ms) begin
          if (s.fault != FAULT_TIMEOUT) begin
            s.fault = FAULT_TIMEOUT;
            s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms,
                      cfg.danger_level);
          end
        end else begin
          if (s.running && chk_el >= cfg.check_interval_ms) begin
            if (drop < $signed({1'b0, cfg.min_drop})) begin
              if (s.fault != FAULT_DRAIN) begin
                s.fault = FAULT_DRAIN;
                s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms,
                          cfg.danger_level);
              end
            end else begin
              // drop was enough: restart the check window
              s.check_start_ms    = item.now_ms;
              s.check_start_level = item.sump_level;
            end
          end
          if (s.fault != FAULT_NONE) begin
            s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms,
                      cfg.danger_level);
          end else if (s.cur_mode == AUTO_MODE) begin
            if (!s.running && item.sump_level >= cfg.start_level) begin
              s = drive(s, 1'b1, item.sump_level, item.tank_level, item.now_ms,
                        cfg.danger_level);
            end else if (s.running && item.sump_level <= cfg.stop_level) begin
              s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms,
                        cfg.danger_level);
            end
          end
        end
      end
      OP_TOGGLE, OP_SET_MODE: begin
        if (s.cur_mode != new_mode) begin
          s.fault    = FAULT_NONE;
          s.cur_mode = new_mode;
          s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms, cfg.danger_level);
        end
      end
      OP_BUTTON: begin
        // button is ignored in auto mode
        if (s.cur_mode == HAND_MODE) begin
          if (s.fault != FAULT_NONE) begin
            s.fault = FAULT_NONE;
            s = drive(s, 1'b0, item.sump_level, item.tank_level, item.now_ms,
                      cfg.danger_level);
          end else begin
            s = drive(s, !s.running, item.sump_level, item.tank_level, item.now_ms,
                      cfg.danger_level);
          end
        end
      end
    endcase
    state_next     = s;
    res.pump_on    = s.running;
    res.mode       = s.cur_mode;
    res.fault      = s.fault;
    res.runtime_ms = s.running ? (item.now_ms - s.run_start_ms) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      state      <= '{running: 1'b0, cur_mode: AUTO_MODE, fault: FAULT_NONE,
                      run_start_ms: '0, check_start_ms: '0, check_start_level: '0};
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/dpg_out_reg.sv =====
// ---------------------------------------------------------------------------
// dpg_out_reg: result register
// Holds one status result until the receiver takes it.
// ---------------------------------------------------------------------------
module dpg_out_reg import dpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

// ===== sv/drain_pump_guard_controller.sv =====
// ---------------------------------------------------------------------------
// drain_pump_guard_controller: sump pump controller with tank and run guards
// Usage:
//   s_axis carries one event per request: tuser is the op (update, toggle
//   mode, set mode, manual button), tdata the requested mode, sump and tank
//   levels and the millisecond timestamp.
//   m_axis returns one status per event: pump drive, mode, latched fault and
//   the current run time.
//   cfg writes one of six thresholds by index; write only while idle.
// Timing:
//   An event is held in the input register, where the decision logic
//   updates the pump state, and then moves into the output register, whose
//   valid bit drives tvalid. One event per cycle is sustained while
//   m_axis_tready stays high, set by the state update against the
//   registered event.
// Reset:
//   rst clears both pipeline stages, stops the pump, selects auto mode,
//   clears faults and loads the default thresholds.
// Stall:
//   While m_axis_tready is low the result is held; one more event is taken
//   into the input register, then s_axis_tready drops until the result moves.
// ---------------------------------------------------------------------------
module drain_pump_guard_controller import dpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [0] mode_req, [7:1] sump_level, [14:8] tank_level, [46:15] now_ms
  input  logic [47:0]        s_axis_tdata,
  // [1:0] op
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] pump_on, [1] mode, [3:2] fault, [35:4] runtime_ms
  output logic [39:0]        m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  assign in_item.op         = s_axis_tuser;
  assign in_item.mode_req   = s_axis_tdata[0];
  assign in_item.sump_level = s_axis_tdata[7:1];
  assign in_item.tank_level = s_axis_tdata[14:8];
  assign in_item.now_ms     = s_axis_tdata[46:15];

  assign m_axis_tdata = {4'b0, out_res.runtime_ms, out_res.fault, out_res.mode,
                         out_res.pump_on};

  dpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dpg_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

endmodule

// ===== sv/dpg_checker.sv =====
// ---------------------------------------------------------------------------
// dpg_checker: port-level checks for the drain pump guard controller
// Watches the result stream for held results and consistent status.
// ---------------------------------------------------------------------------
module dpg_checker import dpg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_idle_runtime: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[35:4] == 32'd0)
    else $error("run time nonzero with pump off");

  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3:2] != FAULT_NONE |-> !m_axis_tdata[0])
    else $error("pump running with a fault latched");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:2] != 2'd3 && m_axis_tdata[39:36] == 4'd0)
    else $error("bad fault code or pad bits");

endmodule

bind drain_pump_guard_controller dpg_checker u_dpg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/drain_pump_guard_controller_tb.sv =====
// ---------------------------------------------------------------------------
// drain_pump_guard_controller_tb: self-checking regression for the pump guard
// Drives event requests on s_axis and status requests out of m_axis with random
// gaps and stalls on both sides. Each accepted event runs through a behavioral
// copy of the controller (thresholds, pump, mode, fault and timers), and the
// status it returns is compared field by field. Directed events hit the
// guards, faults, mode changes and register extremes, then random phases run
// drain cycles under several threshold settings.
// ---------------------------------------------------------------------------
module drain_pump_guard_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SQUEEZE_AT  = 120;
  localparam int unsigned SQUEEZE_LEN = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;

  drain_pump_guard_controller DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the controller
  cfg_t    thr;
  state_t  plant;

  item_t   event_backlog[$];
  result_t status_due[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned statuses_checked = 0;
  int unsigned events_sent = 0;
  int unsigned settings_used = 1;
  int unsigned op_tally[4] = '{0, 0, 0, 0};
  int unsigned timeout_seen = 0;
  int unsigned drain_seen = 0;
  int unsigned cycles = 0;

  // stimulus plant: time and sump level drift between events
  logic [TIME_W-1:0] sim_now = 32'd800000;
  int unsigned       sim_sump = 50;

  function automatic void set_pump(logic on, logic [LEVEL_W-1:0] sump, tank,
                                   logic [TIME_W-1:0] now);
    if (on && plant.fault != FAULT_NONE) return;
    if (on && tank >= thr.danger_level) return;
    if (plant.running == on) return;
    plant.running = on;
    if (on) begin
      plant.run_start_ms = now;
      plant.check_start_ms = now;
      plant.check_start_level = sump;
    end else begin
      plant.run_start_ms = '0;
      plant.check_start_ms = '0;
    end
  endfunction

  function automatic void latch_fault(fault_t code, logic [LEVEL_W-1:0] sump, tank,
                                      logic [TIME_W-1:0] now);
    if (plant.fault == code) return;
    plant.fault = code;
    set_pump(1'b0, sump, tank, now);
  endfunction

  function automatic void switch_mode(logic m, logic [LEVEL_W-1:0] sump, tank,
                                      logic [TIME_W-1:0] now);
    if (plant.cur_mode == m) return;
    plant.fault = FAULT_NONE;
    plant.cur_mode = m;
    set_pump(1'b0, sump, tank, now);
  endfunction

  function automatic void take_update(logic [LEVEL_W-1:0] sump, tank,
                                      logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] run_age;
    logic [TIME_W-1:0] check_age;
    int                drop;
    run_age = now - plant.run_start_ms;
    check_age = now - plant.check_start_ms;
    if (tank >= thr.danger_level) begin
      set_pump(1'b0, sump, tank, now);
      return;
    end
    if (plant.running && run_age >= thr.max_runtime_ms) begin
      latch_fault(FAULT_TIMEOUT, sump, tank, now);
      return;
    end
    if (plant.running && check_age >= thr.check_interval_ms) begin
      // a rise in level is a negative drop
      drop = int'(plant.check_start_level) - int'(sump);
      if (drop < int'(thr.min_drop)) begin
        latch_fault(FAULT_DRAIN, sump, tank, now);
      end else begin
        plant.check_start_ms = now;
        plant.check_start_level = sump;
      end
    end
    if (plant.fault != FAULT_NONE) begin
      set_pump(1'b0, sump, tank, now);
      return;
    end
    if (plant.cur_mode != AUTO_MODE) return;
    if (!plant.running && sump >= thr.start_level) set_pump(1'b1, sump, tank, now);
    else if (plant.running && sump <= thr.stop_level) set_pump(1'b0, sump, tank, now);
  endfunction

  function automatic result_t predict_status(item_t ev);
    result_t r;
    case (ev.op)
      OP_UPDATE:   take_update(ev.sump_level, ev.tank_level, ev.now_ms);
      OP_TOGGLE:   switch_mode(~plant.cur_mode, ev.sump_level, ev.tank_level, ev.now_ms);
      OP_SET_MODE: switch_mode(ev.mode_req, ev.sump_level, ev.tank_level, ev.now_ms);
      OP_BUTTON: begin
        // button does nothing in auto mode
        if (plant.cur_mode == HAND_MODE) begin
          if (plant.fault != FAULT_NONE) begin
            plant.fault = FAULT_NONE;
            set_pump(1'b0, ev.sump_level, ev.tank_level, ev.now_ms);
          end else begin
            set_pump(!plant.running, ev.sump_level, ev.tank_level, ev.now_ms);
          end
        end
      end
    endcase
    r.pump_on = plant.running;
    r.mode = plant.cur_mode;
    r.fault = plant.fault;
    r.runtime_ms = plant.running ? ev.now_ms - plant.run_start_ms : '0;
    return r;
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // event driver
  item_t       on_bus;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_due.push_back(predict_status(on_bus));
        op_tally[on_bus.op]++;
        events_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (event_backlog.size() > 0) begin
          on_bus = event_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, on_bus.now_ms, on_bus.tank_level, on_bus.sump_level,
                           on_bus.mode_req};
          s_axis_tuser <= on_bus.op;
          send_gap = pick_gap(src_idle_pct);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // status monitor
  result_t     got;
  result_t     want;
  int unsigned sink_stall = 0;
  bit          squeezed = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pump_on = m_axis_tdata[0];
        got.mode = m_axis_tdata[1];
        got.fault = m_axis_tdata[3:2];
        got.runtime_ms = m_axis_tdata[35:4];
        statuses_checked++;
        if (status_due.size() == 0) begin
          $error("status request with no event outstanding: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (want.fault == FAULT_TIMEOUT) timeout_seen++;
          if (want.fault == FAULT_DRAIN) drain_seen++;
          check_field("pump_on", 32'(want.pump_on), 32'(got.pump_on));
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("fault", 32'(want.fault), 32'(got.fault));
          check_field("runtime_ms", want.runtime_ms, got.runtime_ms);
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!squeezed && statuses_checked >= SQUEEZE_AT) begin
        // hold off long enough for the input side to back up
        squeezed = 1'b1;
        sink_stall = SQUEEZE_LEN - 1;
        m_axis_tready <= 1'b0;
      end else begin
        sink_stall = pick_gap(snk_idle_pct);
        if (sink_stall > 0) begin
          sink_stall--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("drain_pump_guard_controller regression: fail");
      $finish;
    end
  end

  task automatic write_threshold(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_LEVEL:    thr.start_level = val[LEVEL_W-1:0];
      REG_STOP_LEVEL:     thr.stop_level = val[LEVEL_W-1:0];
      REG_DANGER_LEVEL:   thr.danger_level = val[LEVEL_W-1:0];
      REG_MAX_RUNTIME:    thr.max_runtime_ms = val;
      REG_CHECK_INTERVAL: thr.check_interval_ms = val;
      REG_MIN_DROP:       thr.min_drop = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_thresholds(int unsigned start, stop, danger,
                                 logic [31:0] max_rt, interval, int unsigned drop);
    write_threshold(REG_START_LEVEL, start);
    write_threshold(REG_STOP_LEVEL, stop);
    write_threshold(REG_DANGER_LEVEL, danger);
    write_threshold(REG_MAX_RUNTIME, max_rt);
    write_threshold(REG_CHECK_INTERVAL, interval);
    write_threshold(REG_MIN_DROP, drop);
    settings_used++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (event_backlog.size() != 0 || s_axis_tvalid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_event(op_t op, logic req, int unsigned sump, tank, logic [31:0] now);
    item_t ev;
    ev.op = op;
    ev.mode_req = req;
    ev.sump_level = LEVEL_W'(sump);
    ev.tank_level = LEVEL_W'(tank);
    ev.now_ms = now;
    event_backlog.push_back(ev);
  endtask

  function automatic item_t make_event(int unsigned step_ms);
    item_t       ev;
    int unsigned roll;
    int unsigned d;
    roll = $urandom_range(0, 99);
    if (roll < 70) ev.op = OP_UPDATE;
    else if (roll < 82) ev.op = OP_BUTTON;
    else if (roll < 91) ev.op = OP_SET_MODE;
    else ev.op = OP_TOGGLE;
    ev.mode_req = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 4) sim_now = $urandom();
    else if (roll < 12) sim_now = sim_now;
    else if (roll < 85) sim_now += $urandom_range(1, step_ms);
    else sim_now += $urandom_range(step_ms, 4 * step_ms);
    // sump most often drains, otherwise creeps up, refills or jumps anywhere
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      sim_sump = $urandom_range(0, 127);
    end else if (roll < 15) begin
      sim_sump = $urandom_range(60, 100);
    end else if (roll < 65) begin
      d = $urandom_range(0, 12);
      sim_sump = (sim_sump > d) ? sim_sump - d : 0;
    end else begin
      sim_sump += $urandom_range(0, 6);
      if (sim_sump > 100) sim_sump = 100;
    end
    ev.sump_level = LEVEL_W'(sim_sump);
    ev.tank_level = LEVEL_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 80)
                                                           : $urandom_range(0, 127));
    ev.now_ms = sim_now;
    return ev;
  endfunction

  task automatic run_random(int unsigned count, step_ms, src_pct, snk_pct);
    @(negedge clk);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) event_backlog.push_back(make_event(step_ms));
    wait_drained();
  endtask

  initial begin
    int unsigned interval;
    thr.start_level = 7'd70;
    thr.stop_level = 7'd30;
    thr.danger_level = 7'd90;
    thr.max_runtime_ms = 32'd600000;
    thr.check_interval_ms = 32'd60000;
    thr.min_drop = 7'd5;
    plant = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default thresholds: drain check pass and fail, guards, wrap, timeout
    @(negedge clk);
    src_idle_pct = 30;
    snk_idle_pct = 30;
    add_event(OP_UPDATE,   1'b0, 70,  0,   32'd1000);
    add_event(OP_UPDATE,   1'b0, 60,  0,   32'd61000);
    add_event(OP_UPDATE,   1'b0, 62,  0,   32'd121000);
    add_event(OP_UPDATE,   1'b0, 80,  0,   32'd122000);
    add_event(OP_BUTTON,   1'b0, 80,  0,   32'd123000);
    add_event(OP_SET_MODE, 1'b1, 80,  0,   32'd124000);
    add_event(OP_SET_MODE, 1'b1, 80,  0,   32'd125000);
    add_event(OP_BUTTON,   1'b0, 50,  95,  32'd126000);
    add_event(OP_BUTTON,   1'b0, 50,  10,  32'hFFFF_F000);
    add_event(OP_UPDATE,   1'b0, 48,  10,  32'h0000_1000);
    add_event(OP_UPDATE,   1'b0, 40,  10,  32'd595904);
    add_event(OP_BUTTON,   1'b0, 40,  10,  32'd596000);
    add_event(OP_BUTTON,   1'b0, 127, 0,   32'd597000);
    add_event(OP_UPDATE,   1'b0, 127, 127, 32'd598000);
    add_event(OP_TOGGLE,   1'b1, 127, 0,   32'd599000);
    add_event(OP_UPDATE,   1'b0, 127, 89,  32'd600000);
    add_event(OP_UPDATE,   1'b0, 30,  0,   32'd601000);
    wait_drained();

    // low extremes: zero runtime limit times out at once
    load_thresholds(0, 127, 127, 32'd0, 32'd1, 127);
    @(negedge clk);
    add_event(OP_UPDATE,   1'b0, 0,   126, 32'd700000);
    add_event(OP_UPDATE,   1'b0, 0,   0,   32'd700000);
    add_event(OP_SET_MODE, 1'b1, 0,   0,   32'd700100);
    add_event(OP_BUTTON,   1'b0, 100, 0,   32'd700200);
    add_event(OP_UPDATE,   1'b0, 100, 0,   32'd700300);
    wait_drained();

    // high extremes: zero danger level refuses every start
    load_thresholds(127, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    @(negedge clk);
    add_event(OP_BUTTON,   1'b0, 127, 0,   32'd700400);
    add_event(OP_BUTTON,   1'b0, 127, 0,   32'd700500);
    add_event(OP_UPDATE,   1'b0, 127, 0,   32'd700600);
    wait_drained();

    // random drain cycles; the long sink hold falls inside the first phase
    load_thresholds(70, 30, 90, 32'd20000, 32'd3000, 5);
    run_random(250, 1500, 5, 20);

    load_thresholds(60, 40, 85, 32'd8000, 32'd1000, 3);
    run_random(220, 600, 40, 40);

    interval = $urandom_range(200, 5000);
    load_thresholds($urandom_range(40, 100), $urandom_range(0, 50), $urandom_range(50, 127),
                    $urandom_range(1000, 50000), interval, $urandom_range(0, 15));
    run_random(200, interval / 2 + 1, 0, 0);

    // zero check interval: every update while running, short of the danger and timeout guards, is a drain check
    load_thresholds(100, 0, 100, 32'd3000, 32'd0, 0);
    run_random(220, 1000, 20, 60);

    load_thresholds($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(1, 20000), $urandom_range(1, 4000), $urandom_range(0, 127));
    run_random(200, $urandom_range(100, 3000), 30, 30);

    repeat (10) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d statuses never returned", status_due.size());
      mismatches++;
    end
    $display("%0d events: %0d update, %0d toggle, %0d set mode, %0d button, %0d settings",
             events_sent, op_tally[OP_UPDATE], op_tally[OP_TOGGLE], op_tally[OP_SET_MODE],
             op_tally[OP_BUTTON], settings_used);
    $display("checked %0d statuses, %0d with timeout fault and %0d with drain fault latched",
             statuses_checked, timeout_seen, drain_seen);
    if (mismatches == 0) begin
      $display("drain_pump_guard_controller regression: pass");
    end else begin
      $display("drain_pump_guard_controller regression: fail");
    end
    $finish;
  end

endmodule
